FILE: design/prx_pkg.sv
package prx_pkg;

    // Deepest minimum run length the buffer supports.
    localparam int MAX_MIN_LENGTH = 16;

    // One cell per byte of a releasing burst (held bytes plus the releasing one).
    localparam int NUM_CELLS = MAX_MIN_LENGTH;

    localparam int BYTE_W = 8;
    localparam int CFG_W  = 5;
    localparam int RUN_W  = $clog2(MAX_MIN_LENGTH + 1);
    localparam int CALC_W = 8;

    localparam logic [CFG_W-1:0]  MIN_LENGTH_RESET = CFG_W'(4);
    localparam logic [BYTE_W-1:0] NEWLINE_CHAR     = 8'h0A;
    localparam logic [BYTE_W-1:0] PRINT_LO         = 8'h20;
    localparam logic [BYTE_W-1:0] PRINT_HI         = 8'h7E;
    localparam logic [BYTE_W-1:0] FILL_CHAR        = 8'h00;

    typedef logic [BYTE_W-1:0] t_byte;
    typedef logic [RUN_W-1:0]  t_run;

    // Control for the row of cells.
    typedef struct packed {
        logic wr;      // store the write byte at wr_idx
        logic shift;   // every cell takes its upstream neighbor's byte; the tail takes filler
        t_run wr_idx;
    } t_chain_ctl;

    // Per-cell control.
    typedef struct packed {
        logic wr;
        logic shift;
    } t_cell_ctl;

endpackage

FILE: design/printable_run_extractor.sv
// Printable run extractor: takes one byte per transfer and passes on only
// runs of printable bytes (0x20..0x7E) at least min_length long, ending
// each passed run with a newline (0x0A) when a non-printable byte arrives.
// Bytes of a run still shorter than the minimum wait in a row of byte
// cells; the byte that brings the run to the minimum is stored behind them
// and the whole row is shifted out through cell 0, one byte per output
// transfer, with o_is_last on the final byte of the burst.
// A releasing byte stalls the input until the row has drained, since the
// burst leaves through the single head cell. Results sit in an output
// register; while a waiting result is stalled the input is stalled too, and
// the next byte is taken in the cycle that result leaves.
// min_length (reset 4) is written through the cfg channel; the user must
// write it only while the block is idle, as the block itself does not
// enforce this. 0 acts as 1 and values above 16 act as 16.
module printable_run_extractor (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    // input byte channel
    input  logic                      i_valid,
    output logic                      o_stall,
    input  logic [prx_pkg::BYTE_W-1:0] i_in_byte,
    // result channel
    output logic                      o_valid,
    input  logic                      i_stall,
    output logic [prx_pkg::BYTE_W-1:0] o_out_char,
    output logic                      o_is_last,
    // configuration write
    input  logic                      i_cfg_valid,
    output logic                      o_cfg_ready,
    input  logic [prx_pkg::CFG_W-1:0] i_cfg_data
);

    logic [prx_pkg::CFG_W-1:0] r_min_length;
    prx_pkg::t_run             r_run,  n_run;   // length of current run (saturates)
    prx_pkg::t_run             r_left, n_left;  // bytes still to drain from the row
    logic                      r_ov,   n_ov;
    prx_pkg::t_byte            r_och,  n_och;
    logic                      r_olast, n_olast;

    logic [prx_pkg::CALC_W-1:0] w_m_wide;
    prx_pkg::t_run              w_m;
    logic                       w_out_free;
    logic                       w_in_acc;
    logic                       w_printable;
    logic                       w_draining;
    logic                       w_release;
    prx_pkg::t_run              w_run_inc;
    prx_pkg::t_chain_ctl        w_ctl;
    prx_pkg::t_byte             w_head;

    // Effective minimum: clamp to 1..MAX_MIN_LENGTH.
    always_comb begin
        w_m_wide = prx_pkg::CALC_W'(r_min_length);
        if (w_m_wide < prx_pkg::CALC_W'(1)) begin
            w_m_wide = prx_pkg::CALC_W'(1);
        end
        if (w_m_wide > prx_pkg::CALC_W'(prx_pkg::MAX_MIN_LENGTH)) begin
            w_m_wide = prx_pkg::CALC_W'(prx_pkg::MAX_MIN_LENGTH);
        end
    end
    assign w_m = w_m_wide[prx_pkg::RUN_W-1:0];

    assign w_out_free  = !r_ov || !i_stall;
    assign w_draining  = (r_left != '0);
    assign o_stall     = w_draining || !w_out_free;
    assign w_in_acc    = i_valid && !o_stall;
    assign w_printable = (i_in_byte >= prx_pkg::PRINT_LO) && (i_in_byte <= prx_pkg::PRINT_HI);
    assign w_run_inc   = r_run + prx_pkg::RUN_W'(1);
    assign w_release   = w_in_acc && w_printable && (w_run_inc == w_m);
    assign o_cfg_ready = 1'b1;

    always_comb begin
        n_run   = r_run;
        n_left  = r_left;
        n_ov    = r_ov;
        n_och   = r_och;
        n_olast = r_olast;
        w_ctl   = '0;
        w_ctl.wr_idx = r_run;

        if (r_ov && !i_stall) begin
            n_ov = 1'b0;
        end

        if (w_draining) begin
            if (w_out_free) begin
                // head cell goes to the output, row moves one place
                n_ov        = 1'b1;
                n_och       = w_head;
                n_olast     = (r_left == prx_pkg::RUN_W'(1));
                n_left      = r_left - prx_pkg::RUN_W'(1);
                w_ctl.shift = 1'b1;
            end
        end else if (w_in_acc) begin
            if (w_printable) begin
                if (w_run_inc < w_m) begin
                    w_ctl.wr = 1'b1;
                    n_run    = w_run_inc;
                end else if (w_run_inc == w_m) begin
                    // releasing byte joins the row, then the row drains
                    w_ctl.wr = 1'b1;
                    n_run    = w_m;
                    n_left   = w_m;
                end else begin
                    n_ov    = 1'b1;
                    n_och   = i_in_byte;
                    n_olast = 1'b1;
                    if (r_run > w_m) begin
                        n_run = w_m;
                    end
                end
            end else begin
                if (r_run >= w_m) begin
                    n_ov    = 1'b1;
                    n_och   = prx_pkg::NEWLINE_CHAR;
                    n_olast = 1'b1;
                end
                n_run = '0;
            end
        end
    end

    prx_chain u_chain (
        .i_clk     (i_clk),
        .i_ctl     (w_ctl),
        .i_wr_data (i_in_byte),
        .o_head    (w_head)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_min_length <= prx_pkg::MIN_LENGTH_RESET;
            r_run        <= '0;
            r_left       <= '0;
            r_ov         <= 1'b0;
        end else begin
            if (i_cfg_valid && o_cfg_ready) begin
                r_min_length <= i_cfg_data;
            end
            r_run  <= n_run;
            r_left <= n_left;
            r_ov   <= n_ov;
        end
    end

    always_ff @(posedge i_clk) begin
        r_och   <= n_och;
        r_olast <= n_olast;
    end

    assign o_valid    = r_ov;
    assign o_out_char = r_och;
    assign o_is_last  = r_olast;

    // A release loads the drain count with the full burst length.
    a_release_len: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_release |=> (r_left == $past(w_m)))
        else $error("drain count does not match burst length");

    // Each drain step presents a result, flagged last only when the row is empty.
    a_drain_step: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_draining && w_out_free) |=> (o_valid && (o_is_last == (r_left == '0))))
        else $error("drain step produced wrong result flags");

    // Run length never passes the largest minimum.
    a_run_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_run <= prx_pkg::RUN_W'(prx_pkg::MAX_MIN_LENGTH))
        else $error("run length out of range");

endmodule

FILE: design/prx_cell.sv
module prx_cell (
    input  logic               i_clk,
    input  prx_pkg::t_cell_ctl i_ctl,
    input  prx_pkg::t_byte     i_wr_data,
    input  prx_pkg::t_byte     i_nb_data,
    output prx_pkg::t_byte     o_data
);

    prx_pkg::t_byte r_data;

    always_ff @(posedge i_clk) begin
        if (i_ctl.wr) begin
            r_data <= i_wr_data;
        end else if (i_ctl.shift) begin
            r_data <= i_nb_data;
        end
    end

    assign o_data = r_data;

endmodule

FILE: design/prx_chain.sv
module prx_chain (
    input  logic                i_clk,
    input  prx_pkg::t_chain_ctl i_ctl,
    input  prx_pkg::t_byte      i_wr_data,
    output prx_pkg::t_byte      o_head
);

    prx_pkg::t_byte    w_data [prx_pkg::NUM_CELLS];
    prx_pkg::t_byte    w_nb   [prx_pkg::NUM_CELLS];
    prx_pkg::t_cell_ctl w_ctl [prx_pkg::NUM_CELLS];

    for (genvar g = 0; g < prx_pkg::NUM_CELLS; g++) begin : g_cell
        // Bytes move toward cell 0; the tail takes filler.
        if (g == prx_pkg::NUM_CELLS - 1) begin : g_tail
            assign w_nb[g] = prx_pkg::FILL_CHAR;
        end else begin : g_mid
            assign w_nb[g] = w_data[g+1];
        end

        assign w_ctl[g].wr    = i_ctl.wr && (i_ctl.wr_idx == prx_pkg::RUN_W'(g));
        assign w_ctl[g].shift = i_ctl.shift;

        prx_cell u_cell (
            .i_clk     (i_clk),
            .i_ctl     (w_ctl[g]),
            .i_wr_data (i_wr_data),
            .i_nb_data (w_nb[g]),
            .o_data    (w_data[g])
        );
    end

    assign o_head = w_data[0];

endmodule
